// ===== design/tfaq_pkg.sv =====
`timescale 1ns / 1ps

package tfaq_pkg;

    localparam int QUEUE_DEPTH  = 256;
    localparam int HANDLE_BITS  = 12;
    localparam int Q_AW         = $clog2(QUEUE_DEPTH);
    localparam int FILL_W       = Q_AW + 1;
    localparam int ENTRY_W      = HANDLE_BITS + 1;
    localparam int PCMW_W       = 9;
    localparam int PCM_WAIT_MAX = (1 << PCMW_W) - 1;
    localparam int DROP_W       = 32;

    localparam logic KIND_SEND  = 1'b0;
    localparam logic KIND_READY = 1'b1;

    typedef enum logic [3:0] {
        ACT_SENT     = 4'd0,
        ACT_QUEUED   = 4'd1,
        ACT_PCM_DROP = 4'd2,
        ACT_FULL     = 4'd3,
        ACT_DISCARD  = 4'd4,
        ACT_REFUSED  = 4'd5,
        ACT_SENT_Q   = 4'd6,
        ACT_IDLE     = 4'd7,
        ACT_IGNORED  = 4'd8
    } t_action;

    typedef struct packed {
        logic                   kind;
        logic [HANDLE_BITS-1:0] frame_handle;
        logic                   is_pcm;
    } t_in_word;

    typedef struct packed {
        t_action                action;
        logic [HANDLE_BITS-1:0] send_handle;
        logic [FILL_W-1:0]      queued_count;
        logic [DROP_W-1:0]      pcm_drop_total;
    } t_out_word;

endpackage

// ===== design/tfaq_ram.sv =====
`timescale 1ns / 1ps

module tfaq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 13
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // A read at the address being written returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tx_frame_admission_queue_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Word
// input     in         i_in_valid/o_in_stall  t_in_word  (kind, frame_handle, is_pcm)
// output    out        o_out_valid/i_out_stall t_out_word (action, send_handle,
//                                             queued_count, pcm_drop_total)
// config    in         psel/penable/pwrite    discard_all at 0x0, link_down at 0x4
//
// One word is accepted per cycle unless o_in_stall is high; its result is registered when the word is processed.
// The queue RAM is read when a word enters the input register, so the head entry
// is ready when that word is processed; a write to the same entry is forwarded.
// Synchronous reset empties the queue and marks the link ready.
// An output stall holds the result register and then the input register.

module tx_frame_admission_queue_top
    import tfaq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic REG_DISCARD_ALL = 1'b0;
    localparam logic REG_LINK_DOWN   = 1'b1;

    logic              r_discard_all;
    logic              r_link_down;
    logic              r_in_valid;
    t_in_word          r_in;
    logic              r_out_valid;
    t_out_word         r_out;
    logic              r_link_ready;
    logic [Q_AW-1:0]   r_head;
    logic [FILL_W-1:0] r_fill;
    logic [PCMW_W-1:0] r_pcm_wait;
    logic [DROP_W-1:0] r_drops;

    logic              n_link_ready;
    logic [Q_AW-1:0]   n_head;
    logic [FILL_W-1:0] n_fill;
    logic [PCMW_W-1:0] n_pcm_wait;
    logic [DROP_W-1:0] n_drops;

    logic              advance;
    logic              proc;
    logic              in_accept;
    logic              cfg_wr;
    logic              push;
    logic [Q_AW:0]     slot_sum;
    logic [Q_AW-1:0]   wr_addr;
    logic [Q_AW-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_entry;
    t_out_word         res;

    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_DISCARD_ALL: prdata = {31'd0, r_discard_all};
            REG_LINK_DOWN:   prdata = {31'd0, r_link_down};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb begin
        slot_sum = {1'b0, r_head} + r_fill;
        if (slot_sum >= (Q_AW+1)'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - (Q_AW+1)'(QUEUE_DEPTH);
        end
        wr_addr = slot_sum[Q_AW-1:0];
    end

    always_comb begin
        n_link_ready = r_link_ready;
        n_head       = r_head;
        n_fill       = r_fill;
        n_pcm_wait   = r_pcm_wait;
        n_drops      = r_drops;
        push         = 1'b0;
        res.action      = ACT_IGNORED;
        res.send_handle = '0;
        if (r_in.kind == KIND_SEND) begin
            if (r_link_down) begin
                res.action = ACT_REFUSED;
            end else if (r_discard_all) begin
                res.action = ACT_DISCARD;
            end else if (r_link_ready) begin
                n_link_ready    = 1'b0;
                res.send_handle = r_in.frame_handle;
                res.action      = ACT_SENT;
            end else if (r_in.is_pcm && (r_pcm_wait != '0)) begin
                n_drops    = r_drops + 1'b1;
                res.action = ACT_PCM_DROP;
            end else if (r_fill == FILL_W'(QUEUE_DEPTH)) begin
                res.action = ACT_FULL;
            end else begin
                push   = 1'b1;
                n_fill = r_fill + 1'b1;
                if (r_in.is_pcm && (r_pcm_wait != PCMW_W'(PCM_WAIT_MAX))) begin
                    n_pcm_wait = r_pcm_wait + 1'b1;
                end
                res.action = ACT_QUEUED;
            end
        end else begin
            if (r_link_down) begin
                res.action = ACT_IGNORED;
            end else if (r_fill == '0) begin
                n_link_ready = 1'b1;
                res.action   = ACT_IDLE;
            end else begin
                if (r_head == Q_AW'(QUEUE_DEPTH - 1)) begin
                    n_head = '0;
                end else begin
                    n_head = r_head + 1'b1;
                end
                n_fill       = r_fill - 1'b1;
                n_link_ready = 1'b0;
                if (rd_entry[0] && (r_pcm_wait != '0)) begin
                    n_pcm_wait = r_pcm_wait - 1'b1;
                end
                res.send_handle = rd_entry[ENTRY_W-1:1];
                res.action      = ACT_SENT_Q;
            end
        end
        res.queued_count   = n_fill;
        res.pcm_drop_total = n_drops;
    end

    assign rd_addr = proc ? n_head : r_head;

    tfaq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (proc && push),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_in.frame_handle, r_in.is_pcm}),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discard_all <= 1'b0;
            r_link_down   <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_link_ready  <= 1'b1;
            r_head        <= '0;
            r_fill        <= '0;
            r_pcm_wait    <= '0;
            r_drops       <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_DISCARD_ALL: r_discard_all <= pwdata[0];
                    REG_LINK_DOWN:   r_link_down   <= pwdata[0];
                    default:         r_link_down   <= r_link_down;
                endcase
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (proc) begin
                r_link_ready <= n_link_ready;
                r_head       <= n_head;
                r_fill       <= n_fill;
                r_pcm_wait   <= n_pcm_wait;
                r_drops      <= n_drops;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (proc) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== design/tfaq_checker.sv =====
`timescale 1ns / 1ps

module tfaq_checker
    import tfaq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("Stalled result word changed.");

    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("Input stalled while output is free.");

    a_handle_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.action != ACT_SENT)
            && (o_out_word.action != ACT_SENT_Q)
        |-> o_out_word.send_handle == '0)
        else $error("Handle reported without a send.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.queued_count <= FILL_W'(QUEUE_DEPTH))
        else $error("Queue count above depth.");

endmodule

bind tx_frame_admission_queue_top tfaq_checker u_tfaq_checker (.*);

// ===== tb/tb_tx_frame_admission_queue_top.sv =====
`timescale 1ns / 1ps

module tb_tx_frame_admission_queue_top;
    import tfaq_pkg::*;

    localparam logic [2:0] REG_DISCARD_ALL = 3'h0;
    localparam logic [2:0] REG_LINK_DOWN   = 3'h4;
    localparam int         IDLE_PCT        = 18;
    localparam int         SETTLE_CYCLES   = 8;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_word  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    logic calm   = 1'b0;
    int   errors = 0;

    logic               discard_all_q = 1'b0;
    logic               link_down_q   = 1'b0;
    logic               link_ready_q  = 1'b1;
    logic [ENTRY_W-1:0] waiting_frames[$];
    logic [PCMW_W-1:0]  pcm_waiting_q = '0;
    logic [DROP_W-1:0]  pcm_drops_q   = '0;
    t_out_word          pending_outcomes[$];

    tx_frame_admission_queue_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    endtask

    function automatic t_out_word admit_frame(t_in_word w);
        t_out_word          r;
        logic [ENTRY_W-1:0] head;
        r = '0;
        if (w.kind == KIND_SEND) begin
            if (link_down_q) begin
                r.action = ACT_REFUSED;
            end else if (discard_all_q) begin
                r.action = ACT_DISCARD;
            end else if (link_ready_q) begin
                link_ready_q  = 1'b0;
                r.send_handle = w.frame_handle;
                r.action      = ACT_SENT;
            end else if (w.is_pcm && pcm_waiting_q != 0) begin
                pcm_drops_q = pcm_drops_q + 1'b1;
                r.action    = ACT_PCM_DROP;
            end else if (waiting_frames.size() >= QUEUE_DEPTH) begin
                r.action = ACT_FULL;
            end else begin
                waiting_frames.push_back({w.frame_handle, w.is_pcm});
                if (w.is_pcm && pcm_waiting_q != PCM_WAIT_MAX)
                    pcm_waiting_q = pcm_waiting_q + 1'b1;
                r.action = ACT_QUEUED;
            end
        end else if (link_down_q) begin
            r.action = ACT_IGNORED;
        end else if (waiting_frames.size() == 0) begin
            link_ready_q = 1'b1;
            r.action     = ACT_IDLE;
        end else begin
            head         = waiting_frames.pop_front();
            link_ready_q = 1'b0;
            if (head[0] && pcm_waiting_q != 0)
                pcm_waiting_q = pcm_waiting_q - 1'b1;
            r.send_handle = head[ENTRY_W-1:1];
            r.action      = ACT_SENT_Q;
        end
        r.queued_count   = FILL_W'(waiting_frames.size());
        r.pcm_drop_total = pcm_drops_q;
        return r;
    endfunction

    // The valid stays high after an acceptance so that back-to-back words never
    // see it lowered and raised in the same time step.
    task automatic send_word(input logic k, input logic [HANDLE_BITS-1:0] h, input logic p);
        t_in_word w;
        w = '{kind: k, frame_handle: h, is_pcm: p};
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pending_outcomes.push_back(admit_frame(w));
    endtask

    task automatic wait_settled();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == REG_DISCARD_ALL)
            discard_all_q = value;
        else
            link_down_q = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {31'b0, value})
            note_mismatch("register readback", 64'(prdata), 64'({31'b0, value}));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_modes(input logic discard, input logic down);
        wait_settled();
        write_reg(REG_DISCARD_ALL, discard);
        write_reg(REG_LINK_DOWN, down);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_outcomes.size() == 0) begin
                note_mismatch("unexpected word", 64'(out_word), 64'd0);
            end else begin
                want = pending_outcomes.pop_front();
                if (out_word.action !== want.action)
                    note_mismatch("action", 64'(out_word.action), 64'(want.action));
                if (out_word.send_handle !== want.send_handle)
                    note_mismatch("send_handle", 64'(out_word.send_handle),
                                  64'(want.send_handle));
                if (out_word.queued_count !== want.queued_count)
                    note_mismatch("queued_count", 64'(out_word.queued_count),
                                  64'(want.queued_count));
                if (out_word.pcm_drop_total !== want.pcm_drop_total)
                    note_mismatch("pcm_drop_total", 64'(out_word.pcm_drop_total),
                                  64'(want.pcm_drop_total));
            end
        end
    end

    task automatic test_link_states();
        send_word(KIND_SEND, 12'hFFF, 1'b0);
        send_word(KIND_SEND, 12'h000, 1'b1);
        send_word(KIND_SEND, 12'h555, 1'b1);
        send_word(KIND_SEND, 12'hAAA, 1'b0);
        send_word(KIND_SEND, 12'h0F0, 1'b1);
        send_word(KIND_READY, 12'hFFF, 1'b1);
        send_word(KIND_SEND, 12'h123, 1'b1);
        send_word(KIND_READY, 12'h000, 1'b0);
        send_word(KIND_READY, 12'h000, 1'b0);
        send_word(KIND_READY, 12'h000, 1'b0);
        send_word(KIND_READY, 12'hFFF, 1'b0);
        send_word(KIND_SEND, 12'hF0F, 1'b1);
        send_word(KIND_READY, 12'h000, 1'b0);
    endtask

    // Discard leaves ready events working; link down outranks discard.
    task automatic test_mode_registers();
        send_word(KIND_SEND, 12'h3C3, 1'b0);
        send_word(KIND_SEND, 12'hC3C, 1'b1);
        set_modes(1'b1, 1'b0);
        send_word(KIND_SEND, 12'h777, 1'b0);
        send_word(KIND_SEND, 12'h888, 1'b1);
        send_word(KIND_READY, 12'h000, 1'b0);
        send_word(KIND_READY, 12'h000, 1'b0);
        set_modes(1'b1, 1'b1);
        send_word(KIND_SEND, 12'hFFF, 1'b1);
        send_word(KIND_READY, 12'h000, 1'b0);
        set_modes(1'b0, 1'b1);
        send_word(KIND_SEND, 12'h000, 1'b0);
        send_word(KIND_READY, 12'hFFF, 1'b1);
        set_modes(1'b0, 1'b0);
    endtask

    task automatic test_queue_full();
        send_word(KIND_SEND, HANDLE_BITS'($urandom), 1'b0);
        while (waiting_frames.size() < QUEUE_DEPTH)
            send_word(KIND_SEND, HANDLE_BITS'($urandom), 1'b0);
        send_word(KIND_SEND, HANDLE_BITS'($urandom), 1'b1);
        send_word(KIND_SEND, HANDLE_BITS'($urandom), 1'b0);
        send_word(KIND_READY, HANDLE_BITS'($urandom), 1'b0);
        send_word(KIND_SEND, HANDLE_BITS'($urandom), 1'b1);
        send_word(KIND_SEND, HANDLE_BITS'($urandom), 1'b1);
        send_word(KIND_SEND, HANDLE_BITS'($urandom), 1'b0);
        while (waiting_frames.size() != 0)
            send_word(KIND_READY, HANDLE_BITS'($urandom), 1'($urandom));
        send_word(KIND_READY, HANDLE_BITS'($urandom), 1'b0);
    endtask

    task automatic test_random_traffic();
        int ready_pct;
        int mode;
        for (int burst = 0; burst < 3; burst++) begin
            mode = $urandom_range(9);
            set_modes(mode == 0 || mode == 2, mode == 1 || mode == 2);
            case ($urandom_range(2))
                0: ready_pct = 15;
                1: ready_pct = 50;
                default: ready_pct = 85;
            endcase
            calm = (burst == 1);
            repeat ($urandom_range(25, 45)) begin
                send_word($urandom_range(99) < ready_pct ? KIND_READY : KIND_SEND,
                          HANDLE_BITS'($urandom), $urandom_range(99) < 35);
            end
            calm = 1'b0;
        end
        set_modes(1'b0, 1'b0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_link_states();
        test_mode_registers();
        test_queue_full();
        test_random_traffic();
        wait_settled();
        if (errors == 0) begin
            $display("tx_frame_admission_queue_top regression: pass");
        end else begin
            $display("tx_frame_admission_queue_top regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tx_frame_admission_queue_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tfaq_pkg.sv
design/tfaq_ram.sv
design/tx_frame_admission_queue_top.sv
design/tfaq_checker.sv
tb/tb_tx_frame_admission_queue_top.sv
